/* hdl/fsqrt_pkg.sv */
// ----------------------------------------------------------------------------
// fsqrt_pkg
// Shared constants and types of the single-precision square root pipeline.
// ----------------------------------------------------------------------------
package fsqrt_pkg;

	localparam logic [31:0] CANON_NAN = 32'h7FFF_FFFF;
	localparam logic [31:0] POS_INF   = 32'h7F80_0000;

	// radicand width and root width of the digit recurrence
	localparam int RAD_W  = 50;
	localparam int ROOT_W = 25;
	localparam int REM_W  = 27;

	// root bits produced per pipeline stage
	localparam int BITS_PER_STAGE = 2;
	localparam int NUM_STAGES     = 13;

	// register addresses
	localparam logic [1:0] ADDR_FLUSH = 2'd0;

	// item classification decided at the front of the pipe
	typedef struct packed {
		logic        special;
		logic [31:0] special_bits;
		logic [7:0]  biased_exp;
	} class_t;

endpackage

/* hdl/float32_square_root_core.sv */
// ----------------------------------------------------------------------------
// float32_square_root_core
// Pipelined IEEE-754 binary32 square root, round to nearest even.
// ----------------------------------------------------------------------------
// Usage:
// Requests enter on operand_valid/operand_ready with operand_bits; results
// leave on root_valid/root_ready with root_bits, one result per request, in
// order. A new request is accepted every cycle while the output drains.
// There is one normalize stage, 13 stages of the digit
// recurrence (two root bits each, 26 bits), and one rounding stage that is
// also the output register. Throughput is one request per cycle while the
// output is not stalled; the recurrence stage depth sets the clock.
// The flush_subnormals register sits at byte address 0 of the APB port;
// the user writes it only while the pipe is empty; the block does not enforce it.
// When the receiver stalls, full stages hold; operand_ready drops only
// while the output register is full and not taken, and empty stages are
// filled even then.
// Reset clears all valid bits and the flush register; payload is not reset.
// ----------------------------------------------------------------------------
module float32_square_root_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [1:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        operand_valid,
	output logic        operand_ready,
	input  logic [31:0] operand_bits,
	output logic        root_valid,
	input  logic        root_ready,
	output logic [31:0] root_bits
);

	localparam int NumStages = fsqrt_pkg::NUM_STAGES;
	localparam int RW = fsqrt_pkg::REM_W;
	localparam int QW = fsqrt_pkg::ROOT_W;
	localparam int DW = fsqrt_pkg::RAD_W;

	logic flush_q;

	// configuration register
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q <= 1'b0;
		end else if (psel && penable && pwrite && paddr == fsqrt_pkg::ADDR_FLUSH) begin
			flush_q <= pwdata[0];
		end
	end
	assign prdata = (paddr == fsqrt_pkg::ADDR_FLUSH) ? {31'd0, flush_q} : 32'd0;

	// pipeline enables: a stage advances when its successor is free
	logic                 v_s1;
	logic                 v_st [NumStages];
	logic                 v_out;
	logic                 adv_out;
	logic [NumStages-1:0] adv_st;
	logic                 adv_s1;

	assign adv_out = !v_out || root_ready;
	always_comb begin
		adv_st[NumStages-1] = adv_out || !v_st[NumStages-1];
		for (int i = NumStages - 2; i >= 0; i--) begin
			adv_st[i] = adv_st[i+1] || !v_st[i];
		end
	end
	assign adv_s1        = adv_st[0] || !v_s1;
	assign operand_ready = adv_s1;

	// stage 1: classify, normalize, make exponent even
	fsqrt_pkg::class_t cls_c, cls_s1;
	logic [DW-1:0]     rad_c, rad_s1;
	logic [4:0]        lz;
	logic [23:0]       mant;
	logic signed [9:0] e_c;
	logic signed [9:0] half_c;

	always_comb begin
		logic        sgn;
		logic [7:0]  ex;
		logic [22:0] fr;
		sgn = operand_bits[31];
		ex  = operand_bits[30:23];
		fr  = operand_bits[22:0];
		cls_c = '0;
		lz = 5'd0;
		for (int b = 22; b >= 0; b--) begin
			if (fr[b] && lz == 5'd0 && !(|(fr >> (b + 1)))) begin
				lz = 5'(23 - b);
			end
		end
		if (ex == 8'd0) begin
			mant = {1'b0, fr} << lz;
			e_c  = -10'sd126 - $signed({5'd0, lz});
		end else begin
			mant = {1'b1, fr};
			e_c  = $signed({2'b00, ex}) - 10'sd127;
		end
		if (e_c[0]) begin
			rad_c  = {25'd0, mant, 1'b0} << 23;
			half_c = (e_c - 10'sd1) >>> 1;
		end else begin
			rad_c  = {26'd0, mant} << 23;
			half_c = e_c >>> 1;
		end
		cls_c.biased_exp = 8'(half_c + 10'sd127);
		if (ex == 8'hFF) begin
			cls_c.special      = 1'b1;
			cls_c.special_bits = (fr != 0 || sgn) ? fsqrt_pkg::CANON_NAN : fsqrt_pkg::POS_INF;
		end else if (ex == 8'd0 && fr == 23'd0) begin
			cls_c.special      = 1'b1;
			cls_c.special_bits = operand_bits;
		end else if (ex == 8'd0 && flush_q) begin
			cls_c.special      = 1'b1;
			cls_c.special_bits = {sgn, 31'd0};
		end else if (sgn) begin
			cls_c.special      = 1'b1;
			cls_c.special_bits = fsqrt_pkg::CANON_NAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= operand_valid;
		end
	end
	always_ff @(posedge clk) begin
		if (adv_s1 && operand_valid) begin
			cls_s1 <= cls_c;
			rad_s1 <= rad_c;
		end
	end

	// recurrence stages: two restoring root-digit steps each
	fsqrt_pkg::class_t cls_st [NumStages];
	logic [DW-1:0]     rad_st [NumStages];
	logic [RW-1:0]     rem_st [NumStages];
	logic [QW-1:0]     q_st   [NumStages];

	for (genvar g = 0; g < NumStages; g++) begin : g_stage
		logic              vin;
		fsqrt_pkg::class_t cin;
		logic [DW-1:0]     din;
		logic [RW-1:0]     rin;
		logic [QW-1:0]     qin;
		logic [DW-1:0]     dnx;
		logic [RW-1:0]     rnx;
		logic [QW-1:0]     qnx;

		if (g == 0) begin : g_first
			assign vin = v_s1;
			assign cin = cls_s1;
			assign din = rad_s1;
			assign rin = '0;
			assign qin = '0;
		end else begin : g_rest
			assign vin = v_st[g-1];
			assign cin = cls_st[g-1];
			assign din = rad_st[g-1];
			assign rin = rem_st[g-1];
			assign qin = q_st[g-1];
		end

		// two steps: bring down two radicand bits, trial subtract 4q+1
		always_comb begin
			logic [RW-1:0] r;
			logic [RW-1:0] t;
			r   = rin;
			qnx = qin;
			dnx = din;
			for (int k = 0; k < fsqrt_pkg::BITS_PER_STAGE; k++) begin
				r   = {r[RW-3:0], dnx[DW-1 -: 2]};
				dnx = dnx << 2;
				t   = {qnx[RW-3:0], 2'b01};
				if (r >= t) begin
					r   = r - t;
					qnx = {qnx[QW-2:0], 1'b1};
				end else begin
					qnx = {qnx[QW-2:0], 1'b0};
				end
			end
			rnx = r;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_st[g] <= 1'b0;
			end else if (adv_st[g]) begin
				v_st[g] <= vin;
			end
		end
		always_ff @(posedge clk) begin
			if (adv_st[g] && vin) begin
				cls_st[g] <= cin;
				rad_st[g] <= dnx;
				rem_st[g] <= rnx;
				q_st[g]   <= qnx;
			end
		end
	end

	// final stage: round (the top root bit is always zero; keep 24 plus the half bit)
	logic [31:0] res_c, res_q;
	always_comb begin
		logic [QW-1:0] q;
		logic [24:0]   r;
		q = q_st[NumStages-1];
		// q holds floor(sqrt(rad*4)); q[0] is the half bit, and a tie cannot occur
		r = {1'b0, q[QW-1:1]} + {24'd0, q[0]};
		if (cls_st[NumStages-1].special) begin
			res_c = cls_st[NumStages-1].special_bits;
		end else begin
			res_c = ({1'b0, cls_st[NumStages-1].biased_exp, 23'd0})
				+ {7'd0, r} - 32'h0080_0000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (adv_out) begin
			v_out <= v_st[NumStages-1];
		end
	end
	always_ff @(posedge clk) begin
		if (adv_out && v_st[NumStages-1]) begin
			res_q <= res_c;
		end
	end

	assign root_valid = v_out;
	assign root_bits  = res_q;

`ifndef SYNTHESIS
	// a held result must not change while stalled
	assert property (@(posedge clk) disable iff (!arst_n)
		root_valid && !root_ready |=> root_valid && $stable(root_bits))
		else $error("result changed while stalled");
	// the input is refused only while the output is blocked
	assert property (@(posedge clk) disable iff (!arst_n)
		!operand_ready |-> root_valid && !root_ready)
		else $error("input refused without output stall");
	// the flush register follows a completed write
	assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && paddr == fsqrt_pkg::ADDR_FLUSH |=> flush_q == $past(pwdata[0]))
		else $error("flush register write lost");
`endif

endmodule

/* tb/float32_square_root_core_tb.sv */
// ----------------------------------------------------------------------------
// float32_square_root_core_tb
// Drives binary32 operands through the square root pipeline, predicts each
// root with an integer restoring square root and checks results in order.
// Covers special values, subnormals with and without flushing, random
// patterns, random idling on both sides and long receiver stalls.
// ----------------------------------------------------------------------------
class root_scoreboard;

	logic [31:0] pending_roots[$];
	int unsigned error_count;
	bit          flush_setting;

	// floor square root of a value below 2^50
	static function automatic logic [63:0] int_sqrt(logic [63:0] v);
		logic [63:0] res;
		logic [63:0] b;
		res = 0;
		b = 64'd1 << 50;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v = v - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	function automatic logic [31:0] predict_root(logic [31:0] x);
		logic        sgn;
		logic [7:0]  ex;
		logic [22:0] fr;
		logic [23:0] mant;
		int          e;
		int          half;
		logic [63:0] wide;
		logic [63:0] r;
		logic [63:0] rem;
		sgn = x[31];
		ex = x[30:23];
		fr = x[22:0];
		if (ex == 8'hFF) begin
			if (fr != 0 || sgn) return fsqrt_pkg::CANON_NAN;
			return fsqrt_pkg::POS_INF;
		end
		if (ex == 0 && fr == 0) return x;
		if (ex == 0 && flush_setting) return {sgn, 31'd0};
		if (sgn) return fsqrt_pkg::CANON_NAN;
		if (ex == 0) begin
			mant = {1'b0, fr};
			e = -126;
			while (!mant[23]) begin
				mant = mant << 1;
				e--;
			end
		end else begin
			mant = {1'b1, fr};
			e = int'(ex) - 127;
		end
		wide = 64'(mant);
		// make the exponent even so it halves exactly
		if (((e + 256) % 2) != 0) begin
			wide = wide << 1;
			e--;
		end
		half = (e + 256) / 2 - 128;
		wide = wide << 23;
		r = int_sqrt(wide);
		rem = wide - r * r;
		if (rem > r) r++;
		return 32'((64'(32'(half + 127)) << 23) + (r - (64'd1 << 23)));
	endfunction

	function void note_operand(logic [31:0] x);
		pending_roots.push_back(predict_root(x));
	endfunction

	function void check_root(logic [31:0] got);
		logic [31:0] want;
		if (pending_roots.size() == 0) begin
			$error("root_bits: no request pending, actual %h", got);
			error_count++;
			return;
		end
		want = pending_roots.pop_front();
		if (got !== want) begin
			$error("root_bits: expected %h actual %h", want, got);
			error_count++;
		end
	endfunction

endclass

module float32_square_root_core_tb;

	localparam int LATENCY = 15;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [1:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        operand_valid;
	logic        operand_ready;
	logic [31:0] operand_bits;
	logic        root_valid;
	logic        root_ready;
	logic [31:0] root_bits;

	root_scoreboard sb;
	int unsigned    cycle_count;
	bit             stall_long;
	bit             sink_enable;

	float32_square_root_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.operand_valid(operand_valid), .operand_ready(operand_ready),
		.operand_bits(operand_bits),
		.root_valid(root_valid), .root_ready(root_ready), .root_bits(root_bits)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// count cycles and stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("float32_square_root_core_tb: errors");
			$finish;
		end
	end

	// check each accepted result against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && root_valid && root_ready) sb.check_root(root_bits);
	end

	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 60) return 0;
		if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver: random ready, with one long hold-off on request
	initial begin
		int g;
		root_ready = 1'b0;
		@(posedge clk iff arst_n);
		forever begin
			if (stall_long) begin
				root_ready <= 1'b0;
				repeat (200) @(posedge clk);
				stall_long = 1'b0;
			end else if (!sink_enable) begin
				root_ready <= 1'b1;
				@(posedge clk);
			end else begin
				g = pick_gap();
				if (g > 0) begin
					root_ready <= 1'b0;
					repeat (g) @(posedge clk);
				end
				root_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic write_flush(bit value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= fsqrt_pkg::ADDR_FLUSH; pwdata <= {31'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk iff pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		sb.flush_setting = value;
	endtask

	// offer one request and hold it until taken
	task automatic send_operand(logic [31:0] x, bit idle);
		int g;
		g = idle ? pick_gap() : 0;
		if (g > 0) begin
			operand_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		operand_valid <= 1'b1;
		operand_bits <= x;
		@(posedge clk iff operand_ready);
		sb.note_operand(x);
	endtask

	task automatic drain();
		operand_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_roots.size() != 0) @(posedge clk);
		repeat (LATENCY + 5) @(posedge clk);
	endtask

	function automatic logic [31:0] random_operand();
		logic [31:0] x;
		x = $urandom();
		case ($urandom_range(0, 9))
			0: x[30:23] = 8'h00;
			1: x[30:23] = 8'hFF;
			2: x[31] = 1'b1;
			3: x[22:0] = $urandom_range(0, 3) == 0 ? 23'd0 : 23'h7FFFFF;
			default: x[31] = ($urandom_range(0, 9) == 0);
		endcase
		return x;
	endfunction

	task automatic run_directed();
		logic [31:0] pats[$];
		pats = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
			32'h7FC0_0000, 32'hFFFF_FFFF, 32'h7F80_0001, 32'h0000_0001,
			32'h8000_0001, 32'h007F_FFFF, 32'h0040_0000, 32'h0080_0000,
			32'h7F7F_FFFF, 32'h3F80_0000, 32'h4080_0000, 32'h4000_0000,
			32'hBF80_0000, 32'h3F7F_FFFF, 32'h3F80_0001, 32'h807F_FFFF};
		foreach (pats[i]) send_operand(pats[i], 1'b0);
	endtask

	initial begin
		sb = new();
		cycle_count = 0;
		stall_long = 1'b0;
		sink_enable = 1'b0;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		operand_valid = 1'b0; operand_bits = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed values under both flush settings
		run_directed();
		drain();
		write_flush(1'b1);
		run_directed();
		drain();
		write_flush(1'b0);

		// random phases with receiver idling, and sender idling in all but phase 2
		sink_enable = 1'b1;
		for (int ph = 0; ph < 4; ph++) begin
			for (int n = 0; n < 400; n++) begin
				if (ph == 1 && n == 50) stall_long = 1'b1;
				send_operand(random_operand(), ph != 2);
			end
			// sender pauses until all results are back
			drain();
			write_flush(ph[0] ? 1'b0 : 1'b1);
		end
		drain();

		if (sb.error_count == 0) begin
			$display("float32_square_root_core_tb: clean");
		end else begin
			$display("float32_square_root_core_tb: errors");
		end
		$finish;
	end

endmodule
